/* hw/rtl/ttt_pkg.sv */
// Shared widths, request and response codes, and control types for the timer task table.
package ttt_pkg;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int HANDLE_W  = 8;
    localparam int DELAY_W   = 16;
    localparam int PENDING_W = 8;
    localparam int SEL_W     = 3;
    localparam int SLOT_ID_W = 3;
    localparam int KIND_W    = 2;

    // Table size default and poll limit
    localparam int DEF_NUM_SLOTS = 8;
    localparam int MAX_DISPATCH  = 8;
    localparam int CNT_W         = $clog2(MAX_DISPATCH);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POLL   = 2'd3;

    // Response codes
    localparam logic [KIND_W-1:0] RESP_ADDED    = 2'd0;
    localparam logic [KIND_W-1:0] RESP_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] RESP_DISPATCH = 2'd2;
    localparam logic [KIND_W-1:0] RESP_NONE     = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic tick;
        logic add;
        logic del;
        logic poll_load;
        logic poll_step;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic step_last;
    } t_sts;

endpackage

/* hw/rtl/ttt_ctrl.sv */
// Controller state machine: decodes requests and sequences the poll scan.
module ttt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [ttt_pkg::REQ_W-1:0] i_req_type,
    input  ttt_pkg::t_sts             i_sts,
    output ttt_pkg::t_cmd             o_cmd,
    output logic                      busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POLL = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign busy   = (r_state == ST_POLL);
    assign accept = start && !busy;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        ttt_pkg::REQ_TICK:   o_cmd.tick = 1'b1;
                        ttt_pkg::REQ_ADD:    o_cmd.add  = 1'b1;
                        ttt_pkg::REQ_DELETE: o_cmd.del  = 1'b1;
                        ttt_pkg::REQ_POLL: begin
                            o_cmd.poll_load = 1'b1;
                            n_state         = ST_POLL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POLL: begin
                o_cmd.poll_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/ttt_datapath.sv */
// Datapath: slot table, free-slot search, poll mask scan and result register.
module ttt_datapath #(
    parameter int NUM_SLOTS = ttt_pkg::DEF_NUM_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttt_pkg::t_cmd                 i_cmd,
    output ttt_pkg::t_sts                 o_sts,
    input  logic [ttt_pkg::HANDLE_W-1:0]  i_task_handle,
    input  logic [ttt_pkg::DELAY_W-1:0]   i_start_delay,
    input  logic [ttt_pkg::DELAY_W-1:0]   i_repeat_period,
    input  logic [ttt_pkg::SEL_W-1:0]     i_slot_sel,
    output logic                          o_resp_valid,
    output logic [ttt_pkg::KIND_W-1:0]    o_resp_kind,
    output logic [ttt_pkg::SLOT_ID_W-1:0] o_slot_id,
    output logic [ttt_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [NUM_SLOTS-1:0] MASK_ONE = NUM_SLOTS'(1);
    localparam logic [ttt_pkg::CNT_W-1:0] CNT_LAST = ttt_pkg::CNT_W'(ttt_pkg::MAX_DISPATCH - 1);

    logic [ttt_pkg::HANDLE_W-1:0]  r_handle  [NUM_SLOTS];
    logic [ttt_pkg::DELAY_W-1:0]   r_delay   [NUM_SLOTS];
    logic [ttt_pkg::DELAY_W-1:0]   r_period  [NUM_SLOTS];
    logic [ttt_pkg::PENDING_W-1:0] r_pending [NUM_SLOTS];

    logic [NUM_SLOTS-1:0]        r_mask;
    logic [ttt_pkg::CNT_W-1:0]   r_cnt;

    logic                          r_valid;
    logic [ttt_pkg::KIND_W-1:0]    r_kind;
    logic [ttt_pkg::SLOT_ID_W-1:0] r_slot;
    logic [ttt_pkg::HANDLE_W-1:0]  r_hout;
    logic                          r_last;

    logic [NUM_SLOTS-1:0] disp_vec;
    logic                 free_any;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     low_idx;
    logic                 step_last;
    logic [IDX_W+2:0]     free_ext;
    logic [IDX_W+2:0]     low_ext;

    // Dispatchable slots and lowest free slot
    always_comb begin
        disp_vec = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            disp_vec[i] = (r_handle[i] != '0) && (r_pending[i] != '0);
            if (r_handle[i] == '0) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Lowest slot still marked in the poll mask
    always_comb begin
        low_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    // Final poll step: at most one mask bit left, or the dispatch limit reached
    assign step_last       = ((r_mask & (r_mask - MASK_ONE)) == '0) || (r_cnt == CNT_LAST);
    assign o_sts.step_last = step_last;

    // Slot ids carry only the low bits of the slot number
    assign free_ext = {3'b000, free_idx};
    assign low_ext  = {3'b000, low_idx};

    // Table updates and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_handle[i]  <= '0;
                r_delay[i]   <= '0;
                r_period[i]  <= '0;
                r_pending[i] <= '0;
            end
            r_mask  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_kind  <= '0;
            r_slot  <= '0;
            r_hout  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            // Tick: count down, or mark a run due and reload
            if (i_cmd.tick) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (r_handle[i] != '0) begin
                        if (r_delay[i] == '0) begin
                            if (r_pending[i] != '1) begin
                                r_pending[i] <= r_pending[i] + 1'b1;
                            end
                            if (r_period[i] != '0) begin
                                r_delay[i] <= r_period[i];
                            end
                        end else begin
                            r_delay[i] <= r_delay[i] - 1'b1;
                        end
                    end
                end
            end

            // Add into the lowest free slot
            if (i_cmd.add) begin
                r_valid <= 1'b1;
                r_last  <= 1'b1;
                if ((i_task_handle != '0) && free_any) begin
                    r_handle[free_idx]  <= i_task_handle;
                    r_delay[free_idx]   <= i_start_delay;
                    r_period[free_idx]  <= i_repeat_period;
                    r_pending[free_idx] <= '0;
                    r_kind <= ttt_pkg::RESP_ADDED;
                    r_slot <= free_ext[ttt_pkg::SLOT_ID_W-1:0];
                    r_hout <= i_task_handle;
                end else begin
                    r_kind <= ttt_pkg::RESP_REJECTED;
                    r_slot <= '0;
                    r_hout <= '0;
                end
            end

            // Delete: only slots reachable by the select field
            if (i_cmd.del) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if ((i < (1 << ttt_pkg::SEL_W)) && (i_slot_sel == ttt_pkg::SEL_W'(i))) begin
                        r_handle[i]  <= '0;
                        r_delay[i]   <= '0;
                        r_period[i]  <= '0;
                        r_pending[i] <= '0;
                    end
                end
            end

            // Poll start: snapshot the slots with due runs
            if (i_cmd.poll_load) begin
                r_mask <= disp_vec;
                r_cnt  <= '0;
            end

            // Poll step: one dispatch per cycle
            if (i_cmd.poll_step) begin
                r_valid <= 1'b1;
                if (r_mask == '0) begin
                    r_kind <= ttt_pkg::RESP_NONE;
                    r_slot <= '0;
                    r_hout <= '0;
                    r_last <= 1'b1;
                end else begin
                    r_kind <= ttt_pkg::RESP_DISPATCH;
                    r_slot <= low_ext[ttt_pkg::SLOT_ID_W-1:0];
                    r_hout <= r_handle[low_idx];
                    r_last <= step_last;
                    if (r_period[low_idx] == '0) begin
                        r_handle[low_idx]  <= '0;
                        r_delay[low_idx]   <= '0;
                        r_period[low_idx]  <= '0;
                        r_pending[low_idx] <= '0;
                    end else begin
                        r_pending[low_idx] <= r_pending[low_idx] - 1'b1;
                    end
                    r_mask[low_idx] <= 1'b0;
                    r_cnt           <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_resp_valid = r_valid;
    assign o_resp_kind  = r_kind;
    assign o_slot_id    = r_slot;
    assign o_handle_out = r_hout;
    assign o_last       = r_last;

endmodule

/* hw/rtl/timer_task_table_core.sv */
// Timer task table top level: request controller joined to the slot datapath.
//
// Usage: drive a request on i_req_type and the payload ports and raise start;
// the transfer happens at a rising edge with start high and busy low.
// Tick, add and delete never raise busy; a tick or delete gives no result,
// an add gives one result in the cycle after the transfer. A schedule poll
// raises busy and emits one result per cycle: the controller enters its poll
// state at the transfer and each poll step registers one result, one per
// dispatched slot (at most 8, lowest slot first) or a single nothing-pending
// result. Busy stays high until the final poll step. The poll scan finds the
// next due slot with a priority encoder over a mask captured at the transfer,
// one per cycle. Each result sits on the o_ ports for one cycle with o_resp_valid
// high; o_last marks the final result of a request. The receiver cannot stall,
// so results are never held. Synchronous reset (i_rst_n low) frees all slots,
// clears all counts and returns the controller to idle.
module timer_task_table_core #(
    parameter int NUM_SLOTS = ttt_pkg::DEF_NUM_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ttt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ttt_pkg::HANDLE_W-1:0]  i_task_handle,
    input  logic [ttt_pkg::DELAY_W-1:0]   i_start_delay,
    input  logic [ttt_pkg::DELAY_W-1:0]   i_repeat_period,
    input  logic [ttt_pkg::SEL_W-1:0]     i_slot_sel,
    output logic                          o_resp_valid,
    output logic [ttt_pkg::KIND_W-1:0]    o_resp_kind,
    output logic [ttt_pkg::SLOT_ID_W-1:0] o_slot_id,
    output logic [ttt_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_last
);

    ttt_pkg::t_cmd cmd;
    ttt_pkg::t_sts sts;

    // Request decode and poll sequencing
    ttt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // Slot table and results
    ttt_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_task_handle   (i_task_handle),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_sel      (i_slot_sel),
        .o_resp_valid    (o_resp_valid),
        .o_resp_kind     (o_resp_kind),
        .o_slot_id       (o_slot_id),
        .o_handle_out    (o_handle_out),
        .o_last          (o_last)
    );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the timer task table core: slot table predictor and request driver.
`timescale 1ns / 1ps

// One result transfer as seen on the o_ ports
typedef struct packed {
    logic [ttt_pkg::KIND_W-1:0]    kind;
    logic [ttt_pkg::SLOT_ID_W-1:0] slot;
    logic [ttt_pkg::HANDLE_W-1:0]  handle;
    logic                          last;
} t_table_resp;

// Own copy of the slot table plus the responses the block still owes
class slot_table_scoreboard;
    logic [ttt_pkg::HANDLE_W-1:0]  slot_hnd  [ttt_pkg::DEF_NUM_SLOTS];
    logic [ttt_pkg::DELAY_W-1:0]   slot_dly  [ttt_pkg::DEF_NUM_SLOTS];
    logic [ttt_pkg::DELAY_W-1:0]   slot_per  [ttt_pkg::DEF_NUM_SLOTS];
    logic [ttt_pkg::PENDING_W-1:0] slot_runs [ttt_pkg::DEF_NUM_SLOTS];
    t_table_resp                   owed[$];
    int                            faults;

    function new();
        faults = 0;
        for (int s = 0; s < ttt_pkg::DEF_NUM_SLOTS; s++) free_slot(s);
    endfunction

    function void free_slot(int s);
        slot_hnd[s]  = '0;
        slot_dly[s]  = '0;
        slot_per[s]  = '0;
        slot_runs[s] = '0;
    endfunction

    function void owe(logic [ttt_pkg::KIND_W-1:0] kind, logic [ttt_pkg::SLOT_ID_W-1:0] slot,
                      logic [ttt_pkg::HANDLE_W-1:0] handle, logic last);
        t_table_resp r;
        r.kind   = kind;
        r.slot   = slot;
        r.handle = handle;
        r.last   = last;
        owed.push_back(r);
    endfunction

    // Accepted request: advance the table and queue the responses it causes
    function void note_request(logic [ttt_pkg::REQ_W-1:0] req,
                               logic [ttt_pkg::HANDLE_W-1:0] hnd,
                               logic [ttt_pkg::DELAY_W-1:0] dly,
                               logic [ttt_pkg::DELAY_W-1:0] per,
                               logic [ttt_pkg::SEL_W-1:0] sel);
        int due;
        int sent;
        int target;
        due    = 0;
        sent   = 0;
        target = -1;
        case (req)
            ttt_pkg::REQ_TICK: begin
                // count down; at zero a run becomes due (saturating) and the delay reloads
                for (int s = 0; s < ttt_pkg::DEF_NUM_SLOTS; s++) begin
                    if (slot_hnd[s] != '0) begin
                        if (slot_dly[s] == '0) begin
                            if (slot_runs[s] != '1) slot_runs[s] = slot_runs[s] + 1'b1;
                            if (slot_per[s] != '0) slot_dly[s] = slot_per[s];
                        end else begin
                            slot_dly[s] = slot_dly[s] - 1'b1;
                        end
                    end
                end
            end
            ttt_pkg::REQ_ADD: begin
                // lowest free slot; zero handle or full table is rejected
                if (hnd != '0) begin
                    for (int s = ttt_pkg::DEF_NUM_SLOTS - 1; s >= 0; s--) begin
                        if (slot_hnd[s] == '0) target = s;
                    end
                end
                if (target < 0) begin
                    owe(ttt_pkg::RESP_REJECTED, '0, '0, 1'b1);
                end else begin
                    slot_hnd[target]  = hnd;
                    slot_dly[target]  = dly;
                    slot_per[target]  = per;
                    slot_runs[target] = '0;
                    owe(ttt_pkg::RESP_ADDED, ttt_pkg::SLOT_ID_W'(target), hnd, 1'b1);
                end
            end
            ttt_pkg::REQ_DELETE: begin
                if (int'(sel) < ttt_pkg::DEF_NUM_SLOTS) free_slot(int'(sel));
            end
            ttt_pkg::REQ_POLL: begin
                for (int s = 0; s < ttt_pkg::DEF_NUM_SLOTS; s++) begin
                    if (slot_hnd[s] != '0 && slot_runs[s] != '0) due++;
                end
                if (due > ttt_pkg::MAX_DISPATCH) due = ttt_pkg::MAX_DISPATCH;
                if (due == 0) begin
                    owe(ttt_pkg::RESP_NONE, '0, '0, 1'b1);
                end else begin
                    // one dispatch per due slot; one-shot slots are freed outright
                    for (int s = 0; s < ttt_pkg::DEF_NUM_SLOTS && sent < due; s++) begin
                        if (slot_hnd[s] != '0 && slot_runs[s] != '0) begin
                            owe(ttt_pkg::RESP_DISPATCH, ttt_pkg::SLOT_ID_W'(s), slot_hnd[s],
                                sent == due - 1);
                            sent++;
                            slot_runs[s] = slot_runs[s] - 1'b1;
                            if (slot_per[s] == '0) free_slot(s);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one result transfer with the oldest owed response
    function void check_result(logic [ttt_pkg::KIND_W-1:0] kind,
                               logic [ttt_pkg::SLOT_ID_W-1:0] slot,
                               logic [ttt_pkg::HANDLE_W-1:0] handle, logic last);
        t_table_resp want;
        if (owed.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("%0t: result with none owed: kind %0d slot %0d handle %h last %0b",
                         $time, kind, slot, handle, last);
        end else begin
            want = owed.pop_front();
            if (want.kind !== kind || want.slot !== slot || want.handle !== handle ||
                want.last !== last) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: exp/act kind %0d/%0d slot %0d/%0d handle %h/%h last %0b/%0b",
                             $time, want.kind, kind, want.slot, slot, want.handle, handle,
                             want.last, last);
            end
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 70;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic                          busy;
    logic [ttt_pkg::REQ_W-1:0]     i_req_type      = '0;
    logic [ttt_pkg::HANDLE_W-1:0]  i_task_handle   = '0;
    logic [ttt_pkg::DELAY_W-1:0]   i_start_delay   = '0;
    logic [ttt_pkg::DELAY_W-1:0]   i_repeat_period = '0;
    logic [ttt_pkg::SEL_W-1:0]     i_slot_sel      = '0;
    logic                          o_resp_valid;
    logic [ttt_pkg::KIND_W-1:0]    o_resp_kind;
    logic [ttt_pkg::SLOT_ID_W-1:0] o_slot_id;
    logic [ttt_pkg::HANDLE_W-1:0]  o_handle_out;
    logic                          o_last;

    logic                 idle_on = 1'b1;
    int                   cycles  = 0;
    slot_table_scoreboard sb;

    timer_task_table_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_task_handle   (i_task_handle),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_sel      (i_slot_sel),
        .o_resp_valid    (o_resp_valid),
        .o_resp_kind     (o_resp_kind),
        .o_slot_id       (o_slot_id),
        .o_handle_out    (o_handle_out),
        .o_last          (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Monitor: check result transfers, then record request transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_resp_valid) sb.check_result(o_resp_kind, o_slot_id, o_handle_out, o_last);
            if (start && !busy)
                sb.note_request(i_req_type, i_task_handle, i_start_delay, i_repeat_period,
                                i_slot_sel);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic [ttt_pkg::REQ_W-1:0] req,
                                input logic [ttt_pkg::HANDLE_W-1:0] hnd,
                                input logic [ttt_pkg::DELAY_W-1:0] dly,
                                input logic [ttt_pkg::DELAY_W-1:0] per,
                                input logic [ttt_pkg::SEL_W-1:0] sel);
        while (idle_on && $urandom_range(0, 99) < 32) begin
            start           <= 1'b0;
            i_req_type      <= ttt_pkg::REQ_W'($urandom());
            i_task_handle   <= ttt_pkg::HANDLE_W'($urandom());
            i_start_delay   <= ttt_pkg::DELAY_W'($urandom());
            i_repeat_period <= ttt_pkg::DELAY_W'($urandom());
            i_slot_sel      <= ttt_pkg::SEL_W'($urandom());
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= req;
        i_task_handle   <= hnd;
        i_start_delay   <= dly;
        i_repeat_period <= per;
        i_slot_sel      <= sel;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        int                           r;
        logic [ttt_pkg::REQ_W-1:0]    req;
        logic [ttt_pkg::HANDLE_W-1:0] hnd;
        logic [ttt_pkg::DELAY_W-1:0]  dly;
        logic [ttt_pkg::DELAY_W-1:0]  per;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty poll, rejected adds, extremes, one-shot freed with runs left
        send_request(ttt_pkg::REQ_POLL,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h00, 16'h0005, 16'h0003, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'hFF, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h01, 16'h0001, 16'h0002, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h80, 16'hFFFF, 16'hFFFF, 3'd0);
        send_request(ttt_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd5);
        send_request(ttt_pkg::REQ_TICK,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_TICK,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_POLL,   8'h00, 16'h0000, 16'h0000, 3'd0);
        // fill the table, then overflow it
        send_request(ttt_pkg::REQ_ADD,    8'h55, 16'h0000, 16'h0001, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'hAA, 16'h0000, 16'h0001, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h12, 16'h0002, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h34, 16'h0000, 16'h0003, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h7E, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'hC3, 16'h0001, 16'h0001, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h99, 16'h0001, 16'h0001, 3'd0);
        send_request(ttt_pkg::REQ_TICK,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_TICK,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_POLL,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd7);
        send_request(ttt_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_ADD,    8'h5A, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_TICK,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_POLL,   8'h00, 16'h0000, 16'h0000, 3'd0);
        send_request(ttt_pkg::REQ_POLL,   8'h00, 16'h0000, 16'h0000, 3'd0);

        // Saturation: a due one-shot slot collects more runs than the count can hold
        for (int s = 0; s < ttt_pkg::DEF_NUM_SLOTS; s++)
            send_request(ttt_pkg::REQ_DELETE, 8'h00, 16'h0000, 16'h0000, ttt_pkg::SEL_W'(s));
        send_request(ttt_pkg::REQ_ADD, 8'h3C, 16'h0000, 16'h0000, 3'd0);
        // back to back, no idle cycles
        idle_on = 1'b0;
        repeat (260) send_request(ttt_pkg::REQ_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
        idle_on = 1'b1;
        send_request(ttt_pkg::REQ_POLL, 8'h00, 16'h0000, 16'h0000, 3'd0);

        // Random mix; short delays and periods so slots come due and get dispatched
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_on = !(n >= 20 && n < 50);
            hnd = ttt_pkg::HANDLE_W'($urandom());
            dly = ttt_pkg::DELAY_W'($urandom());
            per = ttt_pkg::DELAY_W'($urandom());
            r = $urandom_range(0, 99);
            if (r < 35) req = ttt_pkg::REQ_TICK;
            else if (r < 57) req = ttt_pkg::REQ_ADD;
            else if (r < 70) req = ttt_pkg::REQ_DELETE;
            else req = ttt_pkg::REQ_POLL;
            if (req == ttt_pkg::REQ_ADD) begin
                if ($urandom_range(0, 11) == 0) hnd = '0;
                if ($urandom_range(0, 99) < 85) dly = ttt_pkg::DELAY_W'($urandom_range(0, 3));
                r = $urandom_range(0, 99);
                if (r < 30) per = '0;
                else if (r < 85) per = ttt_pkg::DELAY_W'($urandom_range(1, 4));
            end
            send_request(req, hnd, dly, per, ttt_pkg::SEL_W'($urandom()));
        end
        start <= 1'b0;

        // Drain owed responses, then watch for strays
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
